// ----- hdl/swra_pkg.sv -----
`default_nettype none
package swra_pkg;

  // fraction bits of the log2 result
  localparam int LOG_TABLE_BITS = 10;
  // magnitude of -log2(score) in units of 2^-LOG_TABLE_BITS
  localparam int LGW = LOG_TABLE_BITS + 5;
  // exponent product after rounding off the Q8.8 fraction
  localparam int NW = LGW + 9;
  localparam int QW = NW - LOG_TABLE_BITS;
  localparam int SHW = QW + 2;
  localparam int CNTW = 5;

  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [16:0] P_ONE = 17'd65536;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_DECAY = 2'd1;

  // classified entry between front and back
  typedef struct packed {
    logic [23:0] row;
    logic [31:0] sample;
    logic [23:0] weight;
    logic [16:0] score;
    logic        counted;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic [23:0] row;
    logic [31:0] smoothed;
    logic        invalid;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_MULN, S_EXP, S_SCALE, S_FACT, S_TERM, S_ACC, S_DCHK, S_DIV, S_OUT
  } state_t;

  // 2^(2^-k) in Q1.30, k = 1..14
  function automatic logic [30:0] root_q30(input logic [CNTW-1:0] k);
    logic [30:0] v;
    case (k)
      5'd1:    v = 31'd1518500250;
      5'd2:    v = 31'd1276901417;
      5'd3:    v = 31'd1170923762;
      5'd4:    v = 31'd1121280436;
      5'd5:    v = 31'd1097253708;
      5'd6:    v = 31'd1085434106;
      5'd7:    v = 31'd1079572136;
      5'd8:    v = 31'd1076653033;
      5'd9:    v = 31'd1075196443;
      5'd10:   v = 31'd1074468888;
      5'd11:   v = 31'd1074105294;
      5'd12:   v = 31'd1073923544;
      5'd13:   v = 31'd1073832680;
      5'd14:   v = 31'd1073787251;
      default: v = Q30_ONE;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sparse_weighted_row_average.sv -----
// channel   direction  handshake               payload
// input     in         push / full             row_id .. last_entry
// result    out        pop / empty             result_row, smoothed, invalid
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An uncounted entry goes straight to accumulation in the back end; a counted
// one first runs the log2 squaring loop and exp2 root products, unless decay or score is zero.
// A row's last entry then passes a divide check and, if needed, the bit-serial divider.
// A two-entry queue takes input while the back end works; results wait in an
// output register. rst is synchronous; it clears the sums, empties the queue and resets the state.
`default_nettype none
module sparse_weighted_row_average (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [23:0] row_id,
  input  wire logic        has_entry,
  input  wire logic [31:0] sample,
  input  wire logic [23:0] weight,
  input  wire logic [16:0] score,
  input  wire logic        score_finite,
  input  wire logic        last_entry,
  output logic             empty,
  input  wire logic        pop,
  output logic [23:0]      result_row,
  output logic [31:0]      smoothed,
  output logic             invalid,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [16:0]       score_threshold;
  logic [15:0]       decay_power;
  swra_pkg::entry_t  f_entry;
  swra_pkg::entry_t  q_data;
  swra_pkg::result_t result;
  logic              q_full;
  logic              q_empty;
  logic              q_rd;
  logic              out_valid;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= 17'd0;
      decay_power     <= 16'd1280;
    end else if (cfg_valid) begin
      if (cfg_index == swra_pkg::CFG_THRESHOLD) score_threshold <= cfg_data[16:0];
      else if (cfg_index == swra_pkg::CFG_DECAY) decay_power <= cfg_data[15:0];
    end
  end

  swra_front u_front (
    .row_id, .has_entry, .sample, .weight, .score, .score_finite, .last_entry,
    .score_threshold, .entry(f_entry)
  );

  swra_queue u_queue (
    .clk, .rst, .wr(push), .wr_data(f_entry), .q_full,
    .rd(q_rd), .rd_data(q_data), .q_empty
  );

  swra_back u_back (
    .clk, .rst, .decay_power, .q_data, .q_empty, .q_rd,
    .result, .out_valid, .pop
  );

  assign full       = q_full;
  assign empty      = !out_valid;
  assign result_row = result.row;
  assign smoothed   = result.smoothed;
  assign invalid    = result.invalid;

endmodule
`default_nettype wire

// ----- hdl/swra_front.sv -----
`default_nettype none
module swra_front (
  input  wire logic [23:0]      row_id,
  input  wire logic             has_entry,
  input  wire logic [31:0]      sample,
  input  wire logic [23:0]      weight,
  input  wire logic [16:0]      score,
  input  wire logic             score_finite,
  input  wire logic             last_entry,
  input  wire logic [16:0]      score_threshold,
  output swra_pkg::entry_t      entry
);

  // an entry counts when present, finite and at or above threshold
  always_comb begin
    entry.row     = row_id;
    entry.sample  = sample;
    entry.weight  = weight;
    // power uses the score clipped to 1.0
    entry.score   = (score > swra_pkg::P_ONE) ? swra_pkg::P_ONE : score;
    entry.counted = has_entry && score_finite && (score >= score_threshold);
    entry.last    = last_entry;
  end

endmodule
`default_nettype wire

// ----- hdl/swra_queue.sv -----
`default_nettype none
module swra_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire swra_pkg::entry_t  wr_data,
  output logic                   q_full,
  input  wire logic              rd,
  output swra_pkg::entry_t       rd_data,
  output logic                   q_empty
);

  swra_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  // two-entry ring
  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !q_full) wr_ptr <= ~wr_ptr;
      if (rd && !q_empty) rd_ptr <= ~rd_ptr;
      count <= count + 2'((wr && !q_full) ? 1 : 0) - 2'((rd && !q_empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/swra_back.sv -----
`default_nettype none
module swra_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [15:0]       decay_power,
  input  wire swra_pkg::entry_t  q_data,
  input  wire logic              q_empty,
  output logic                   q_rd,
  output swra_pkg::result_t      result,
  output logic                   out_valid,
  input  wire logic              pop
);

  localparam int LTB = swra_pkg::LOG_TABLE_BITS;
  localparam int CW = swra_pkg::CNTW;

  swra_pkg::state_t state, state_next;
  swra_pkg::entry_t e;

  logic [CW-1:0]              cnt;
  logic [4:0]                 pnorm;
  logic [30:0]                x;
  logic [LTB-1:0]             frac;
  logic [swra_pkg::NW-1:0]    n;
  logic [30:0]                m;
  logic [16:0]                pw;
  logic [24:0]                f;
  logic [41:0]                prod;
  logic signed [63:0]         wsum;
  logic [47:0]                ws;
  logic [47:0]                rem;
  logic [15:0]                alo;
  logic [31:0]                quo;
  logic                       sat;
  logic                       neg_r;

  // leading one of the clipped score
  function automatic logic [4:0] lead_one(input logic [16:0] s);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (s[i]) p = 5'(i);
    end
    return p;
  endfunction

  // datapath terms
  logic [4:0]                 lead;
  logic [61:0]                sq;
  logic [31:0]                sq30;
  logic [swra_pkg::LGW-1:0]   neg_lg;
  logic [swra_pkg::LGW+15:0]  nprod;
  logic [swra_pkg::LGW+16:0]  nsum;
  logic [LTB-1:0]             r;
  logic [swra_pkg::QW-1:0]    q;
  logic [LTB:0]               g;
  logic [LTB-1:0]             gsh;
  logic [61:0]                mprod;
  logic [62:0]                mround;
  logic [swra_pkg::SHW-1:0]   sh;
  logic [39:0]                psum;
  logic [40:0]                fprod;
  logic [31:0]                mag;
  logic [56:0]                tprod;
  logic [42:0]                term;
  logic [64:0]                s65;
  logic [48:0]                ws49;
  logic [63:0]                amag;
  logic [48:0]                r2;
  logic [32:0]                qv;
  logic [31:0]                smag;
  logic                       load;

  always_comb begin
    lead   = lead_one(q_data.score);
    sq     = 62'(x) * 62'(x);
    sq30   = sq[61:30];
    neg_lg = (swra_pkg::LGW'(5'd16 - pnorm) << LTB) - swra_pkg::LGW'(frac);
    nprod  = (swra_pkg::LGW+16)'(neg_lg) * (swra_pkg::LGW+16)'(decay_power);
    nsum   = {1'b0, nprod} + (swra_pkg::LGW+17)'(128);
    r      = n[LTB-1:0];
    q      = n[swra_pkg::NW-1:LTB];
    g      = (LTB+1)'(1 << LTB) - {1'b0, r};
    gsh    = g[LTB-1:0] << cnt;
    mprod  = 62'(m) * 62'(swra_pkg::root_q30(cnt + CW'(1)));
    mround = {1'b0, mprod} + 63'(1 << 29);
    sh     = swra_pkg::SHW'(14) + swra_pkg::SHW'(q) + swra_pkg::SHW'(r != '0);
    psum   = 40'(m) + (40'd1 << (sh - swra_pkg::SHW'(1)));
    fprod  = 41'(e.weight) * 41'(pw);
    mag    = e.sample[31] ? (32'd0 - e.sample) : e.sample;
    tprod  = 57'(mag) * 57'(f);
    term   = e.sample[31] ? (43'd0 - {1'b0, prod}) : {1'b0, prod};
    s65    = {wsum[63], wsum} + {{22{term[42]}}, term};
    ws49   = {1'b0, ws} + 49'(f);
    amag   = wsum[63] ? (64'd0 - wsum) : wsum;
    r2     = {rem, alo[15]};
    qv     = sat ? 33'h1_0000_0000 : {1'b0, quo};
    if (neg_r) smag = (qv > 33'h0_8000_0000) ? 32'h8000_0000 : qv[31:0];
    else       smag = (qv > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qv[31:0];
    load   = (state == swra_pkg::S_OUT) && (!out_valid || pop);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and queue read
  always_comb begin
    state_next = state;
    q_rd = 1'b0;
    case (state)
      swra_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          if (!q_data.counted) state_next = swra_pkg::S_ACC;
          else if (decay_power == 16'd0 || q_data.score == 17'd0)
            state_next = swra_pkg::S_FACT;
          else state_next = swra_pkg::S_LOG;
        end
      end
      swra_pkg::S_LOG: begin
        if (cnt == CW'(LTB - 1)) state_next = swra_pkg::S_MULN;
      end
      swra_pkg::S_MULN: state_next = swra_pkg::S_EXP;
      swra_pkg::S_EXP: begin
        if (r == '0 || cnt == CW'(LTB - 1)) state_next = swra_pkg::S_SCALE;
      end
      swra_pkg::S_SCALE: state_next = swra_pkg::S_FACT;
      swra_pkg::S_FACT:  state_next = swra_pkg::S_TERM;
      swra_pkg::S_TERM:  state_next = swra_pkg::S_ACC;
      swra_pkg::S_ACC: begin
        state_next = e.last ? swra_pkg::S_DCHK : swra_pkg::S_IDLE;
      end
      swra_pkg::S_DCHK: begin
        if (ws == '0 || amag >= {ws, 16'd0}) state_next = swra_pkg::S_OUT;
        else state_next = swra_pkg::S_DIV;
      end
      swra_pkg::S_DIV: begin
        if (cnt == CW'(31)) state_next = swra_pkg::S_OUT;
      end
      swra_pkg::S_OUT: begin
        if (!out_valid || pop) state_next = swra_pkg::S_IDLE;
      end
      default: state_next = swra_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      wsum <= '0;
      ws   <= '0;
    end else begin
      case (state)
        swra_pkg::S_IDLE: begin
          if (!q_empty) begin
            e     <= q_data;
            pw    <= (decay_power == 16'd0) ? swra_pkg::P_ONE : 17'd0;
            pnorm <= lead;
            x     <= 31'(q_data.score) << (5'd30 - lead);
            frac  <= '0;
            cnt   <= '0;
          end
        end
        swra_pkg::S_LOG: begin
          // square, renormalize, one fraction bit per step
          if (sq30[31]) begin
            x    <= sq30[31:1];
            frac <= {frac[LTB-2:0], 1'b1};
          end else begin
            x    <= sq30[30:0];
            frac <= {frac[LTB-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
        end
        swra_pkg::S_MULN: begin
          n   <= swra_pkg::NW'(nsum >> 8);
          m   <= swra_pkg::Q30_ONE;
          cnt <= '0;
        end
        swra_pkg::S_EXP: begin
          // one table root per step
          if (gsh[LTB-1]) m <= 31'(mround >> 30);
          cnt <= cnt + CW'(1);
        end
        swra_pkg::S_SCALE: begin
          pw <= (sh >= swra_pkg::SHW'(40)) ? 17'd0 : 17'(psum >> sh);
        end
        swra_pkg::S_FACT: begin
          f <= 25'((42'(fprod) + 42'd32768) >> 16);
        end
        swra_pkg::S_TERM: begin
          prod <= 42'((58'(tprod) + 58'd32768) >> 16);
        end
        swra_pkg::S_ACC: begin
          if (e.counted) begin
            if (s65[64] != s65[63]) wsum <= s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else wsum <= s65[63:0];
            ws <= ws49[48] ? {48{1'b1}} : ws49[47:0];
          end
        end
        swra_pkg::S_DCHK: begin
          neg_r <= wsum[63];
          sat   <= (amag >= {ws, 16'd0});
          rem   <= amag[63:16];
          alo   <= amag[15:0];
          quo   <= '0;
          cnt   <= '0;
        end
        swra_pkg::S_DIV: begin
          // restoring division, one quotient bit per step
          if (r2 >= {1'b0, ws}) begin
            rem <= 48'(r2 - {1'b0, ws});
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= r2[47:0];
            quo <= {quo[30:0], 1'b0};
          end
          alo <= {alo[14:0], 1'b0};
          cnt <= cnt + CW'(1);
        end
        swra_pkg::S_OUT: begin
          if (load) begin
            result.row      <= e.row;
            result.invalid  <= (ws == '0);
            result.smoothed <= (ws == '0) ? 32'd0 : (neg_r ? (32'd0 - smag) : smag);
            wsum <= '0;
            ws   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/swra_checker.sv -----
`default_nettype none
module swra_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] smoothed,
  input wire logic [23:0] result_row,
  input wire logic        invalid
);

  // reset leaves no result and room for input
  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("reset state wrong");

  // an invalid result carries zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && invalid) |-> (smoothed == 32'd0))
    else $error("invalid result nonzero");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(smoothed) && $stable(result_row)))
    else $error("result changed while waiting");

endmodule

bind sparse_weighted_row_average swra_checker u_checker (
  .clk, .rst, .full, .empty, .pop, .smoothed, .result_row, .invalid
);
`default_nettype wire

// ----- dv/sparse_weighted_row_average_tb.sv -----
`default_nettype none
module sparse_weighted_row_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CYCLES = 3000000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int SETTLE_CYCLES = 120;
  localparam logic [63:0] WSUM_LIMIT = 64'd281474976710655;

  // root products 2^(2^-k) in Q1.30
  localparam logic [30:0] ROOTS [1:14] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436, 31'd1097253708,
    31'd1085434106, 31'd1079572136, 31'd1076653033, 31'd1075196443, 31'd1074468888,
    31'd1074105294, 31'd1073923544, 31'd1073832680, 31'd1073787251};

  typedef struct packed {
    logic [23:0] row_id;
    logic        has_entry;
    logic [31:0] sample;
    logic [23:0] weight;
    logic [16:0] score;
    logic        score_finite;
    logic        last_entry;
  } entry_item_t;

  // directed row: item, whether a fixed result is typed in, and that result
  typedef struct {
    entry_item_t       item;
    bit                fixed;
    swra_pkg::result_t fixed_res;
  } directed_row_t;

  logic clk, rst;
  logic push, full, empty, pop;
  logic [23:0] row_id, result_row;
  logic has_entry, score_finite, last_entry, invalid;
  logic [31:0] sample, smoothed;
  logic [23:0] weight;
  logic [16:0] score;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  sparse_weighted_row_average i_dut (.*);

  // predictor state
  logic [16:0]       thresh_q;
  logic [15:0]       decay_q;
  longint            acc_weighted;
  logic [63:0]       acc_weight;
  swra_pkg::result_t pending_results[$];

  int  mismatches = 0, results_seen = 0, invalid_seen = 0, items_sent = 0;
  int  cycle_count = 0;
  bit  long_hold = 0;
  bit  stim_done = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("[sparse_weighted_row_average] ERROR");
      $finish;
    end
  end

  function automatic longint unsigned log2_q(input logic [16:0] s);
    int p;
    logic [63:0] x, frac;
    p = 16;
    frac = 0;
    while (p > 0 && s[p] == 1'b0) p--;
    x = 64'(s) << (30 - p);
    for (int i = 0; i < swra_pkg::LOG_TABLE_BITS; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'(swra_pkg::Q30_ONE) << 1)) begin
        frac[0] = 1'b1;
        x = x >> 1;
      end
    end
    // returns magnitude of negative log2 (score <= 1.0)
    return longint'(16 - p) * (longint'(1) << swra_pkg::LOG_TABLE_BITS) - longint'(frac);
  endfunction

  function automatic logic [63:0] score_power(input logic [16:0] s, input logic [15:0] d);
    logic [63:0] n, q, r, m, sh, g;
    if (d == 0) return 64'd65536;
    if (s == 0) return 64'd0;
    if (s > swra_pkg::P_ONE) s = swra_pkg::P_ONE;
    n = log2_q(s) * 64'(d);
    n = (n + 128) >> 8;
    q = n >> swra_pkg::LOG_TABLE_BITS;
    r = n & ((64'd1 << swra_pkg::LOG_TABLE_BITS) - 1);
    m = 64'(swra_pkg::Q30_ONE);
    sh = 14 + q;
    if (r != 0) begin
      g = (64'd1 << swra_pkg::LOG_TABLE_BITS) - r;
      for (int k = 1; k <= swra_pkg::LOG_TABLE_BITS; k++)
        if (g[swra_pkg::LOG_TABLE_BITS - k])
          m = (m * 64'(ROOTS[k]) + 64'(swra_pkg::Q30_ONE >> 1)) >> 30;
      sh = sh + 1;
    end
    if (sh >= 40) return 64'd0;
    return (m + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [31:0] quotient_q16();
    logic neg;
    logic [63:0] a, q1, r1, mag;
    neg = acc_weighted < 0;
    a = neg ? (64'd0 - 64'(acc_weighted)) : 64'(acc_weighted);
    q1 = a / acc_weight;
    r1 = a % acc_weight;
    if (q1 > 65536) mag = 64'h8000_0000;
    else mag = (q1 << 16) + ((r1 << 16) / acc_weight);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // fold one accepted entry into the running sums; queue the row result if it closes
  function automatic void accumulate_entry(input entry_item_t it);
    logic [63:0] f, mag, prod;
    longint term;
    swra_pkg::result_t res;
    if (it.has_entry && it.score_finite && it.score >= thresh_q) begin
      f = (64'(it.weight) * score_power(it.score, decay_q) + 32768) >> 16;
      mag = it.sample[31] ? (64'h1_0000_0000 - 64'(it.sample)) : 64'(it.sample);
      prod = (mag * f + 32768) >> 16;
      term = it.sample[31] ? -longint'(prod) : longint'(prod);
      if (term > 0 && acc_weighted > 64'sh7FFF_FFFF_FFFF_FFFF - term)
        acc_weighted = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (term < 0 && acc_weighted < 64'sh8000_0000_0000_0000 - term)
        acc_weighted = 64'sh8000_0000_0000_0000;
      else acc_weighted = acc_weighted + term;
      acc_weight = acc_weight + f;
      if (acc_weight > WSUM_LIMIT) acc_weight = WSUM_LIMIT;
    end
    if (!it.last_entry) return;
    res.row = it.row_id;
    if (acc_weight == 0) begin
      res.smoothed = 0;
      res.invalid = 1;
    end else begin
      res.smoothed = quotient_q16();
      res.invalid = 0;
    end
    pending_results.push_back(res);
    acc_weighted = 0;
    acc_weight = 0;
  endfunction

  // result side: pop pattern plus an optional long hold-off
  logic [3:0] stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_phase <= '0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (long_hold) pop <= 1'b0;
      else if (stall_phase[3]) pop <= 1'b1;
      else pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // compare accepted results against the oldest expectation
  always @(posedge clk) begin
    swra_pkg::result_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (invalid) invalid_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result row %0h", result_row);
      end else begin
        want = pending_results.pop_front();
        if (want.row !== result_row || want.smoothed !== smoothed ||
            want.invalid !== invalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp row %0h val %0h inv %0b, got row %0h val %0h inv %0b",
                     want.row, want.smoothed, want.invalid, result_row, smoothed, invalid);
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps pushing
  initial begin
    wait (items_sent > 300);
    long_hold = 1;
    repeat (400) @(posedge clk);
    long_hold = 0;
  end

  task automatic send_entry(input entry_item_t it);
    push <= 1'b1;
    {row_id, has_entry, sample, weight, score, score_finite, last_entry} <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    accumulate_entry(it);
    items_sent++;
  endtask

  task automatic stop_push();
    push <= 1'b0;
  endtask

  // leaves cfg_valid high so back-to-back writes need one drive per step
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == swra_pkg::CFG_THRESHOLD) thresh_q = val[16:0];
    else if (idx == swra_pkg::CFG_DECAY) decay_q = val[15:0];
  endtask

  task automatic stop_cfg();
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic entry_item_t random_entry(input bit close_row);
    entry_item_t it;
    int pick;
    it.row_id = $urandom_range(0, 24'hFFFFFF);
    it.has_entry = ($urandom_range(0, 15) != 0);
    it.sample = $urandom;
    pick = $urandom_range(0, 9);
    it.weight = (pick == 0) ? 24'hFFFFFF : (pick < 5) ? 24'h010000 : 24'($urandom);
    pick = $urandom_range(0, 9);
    it.score = (pick == 0) ? 17'd0 : (pick == 1) ? 17'h1FFFF :
               (pick == 2) ? 17'h10000 : 17'($urandom_range(1, 65536));
    it.score_finite = ($urandom_range(0, 15) != 0);
    it.last_entry = close_row;
    return it;
  endfunction

  // directed rows
  directed_row_t dir_rows[$];
  function automatic void add_row(input entry_item_t it, input bit fx,
                                  input swra_pkg::result_t r);
    directed_row_t d;
    d.item = it; d.fixed = fx; d.fixed_res = r;
    dir_rows.push_back(d);
  endfunction

  initial begin
    entry_item_t it;
    swra_pkg::result_t none, r;
    int row_len, phase;
    rst = 1; push = 0; cfg_valid = 0; cfg_index = swra_pkg::CFG_THRESHOLD; cfg_data = 0;
    row_id = 0; has_entry = 0; sample = 0; weight = 0; score = 0;
    score_finite = 0; last_entry = 0;
    thresh_q = 0; decay_q = 16'd1280; acc_weighted = 0; acc_weight = 0;
    none = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty row right after reset, no entry, not finite, maxima
    r = '{row: 24'hFFFFFF, smoothed: 32'd0, invalid: 1'b1};
    add_row('{24'hFFFFFF, 1'b0, 32'h7FFFFFFF, 24'hFFFFFF, 17'h10000, 1'b1, 1'b1}, 1, r);
    r = '{row: 24'd0, smoothed: 32'd0, invalid: 1'b1};
    add_row('{24'd0, 1'b1, 32'h12345678, 24'hFFFFFF, 17'h10000, 1'b0, 1'b1}, 1, r);
    // zero score with decay 5 gives zero factor -> invalid
    r = '{row: 24'd5, smoothed: 32'd0, invalid: 1'b1};
    add_row('{24'd5, 1'b1, 32'h00010000, 24'h010000, 17'd0, 1'b1, 1'b1}, 1, r);
    // score one, weight one: average is the sample itself
    r = '{row: 24'd6, smoothed: 32'h80000000, invalid: 1'b0};
    add_row('{24'd6, 1'b1, 32'h80000000, 24'h010000, 17'h10000, 1'b1, 1'b1}, 1, r);
    r = '{row: 24'd7, smoothed: 32'h7FFFFFFF, invalid: 1'b0};
    add_row('{24'd7, 1'b1, 32'h7FFFFFFF, 24'h010000, 17'h1FFFF, 1'b1, 1'b1}, 1, r);
    // multi-entry rows checked by prediction
    add_row('{24'd8, 1'b1, 32'h7FFFFFFF, 24'hFFFFFF, 17'h10000, 1'b1, 1'b0}, 0, none);
    add_row('{24'd8, 1'b1, 32'h80000000, 24'h000001, 17'h08000, 1'b1, 1'b0}, 0, none);
    add_row('{24'd8, 1'b0, 32'h0, 24'h0, 17'h0, 1'b0, 1'b0}, 0, none);
    add_row('{24'd8, 1'b1, 32'hFFFF0000, 24'h123456, 17'h0C000, 1'b1, 1'b1}, 0, none);
    add_row('{24'd9, 1'b1, 32'h00030000, 24'h000001, 17'h00001, 1'b1, 1'b1}, 0, none);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].fixed) begin
        // the typed-in result must agree with the predictor too
        send_entry(dir_rows[i].item);
        if (pending_results[$] !== dir_rows[i].fixed_res) begin
          mismatches++;
          $display("directed row %0d: predictor disagrees with table", i);
          pending_results[$] = dir_rows[i].fixed_res;
        end
      end else send_entry(dir_rows[i].item);
    end
    stop_push();
    drain_results();

    // configuration phases, extremes included, then random rows
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(swra_pkg::CFG_DECAY, 32'd0);
                 write_reg(swra_pkg::CFG_THRESHOLD, 32'd0); end
        1: begin write_reg(swra_pkg::CFG_DECAY, 32'hFFFF);
                 write_reg(swra_pkg::CFG_THRESHOLD, 32'h1FFFF); end
        2: begin write_reg(swra_pkg::CFG_DECAY, 32'd256);
                 write_reg(swra_pkg::CFG_THRESHOLD, 32'h10000); end
        3: begin write_reg(swra_pkg::CFG_DECAY, 32'($urandom_range(1, 4096)));
                 write_reg(swra_pkg::CFG_THRESHOLD, 32'($urandom_range(0, 65536))); end
        4: begin write_reg(swra_pkg::CFG_DECAY, 32'h7FFF_FFFF ^ 32'h7FFF_0000);
                 write_reg(swra_pkg::CFG_THRESHOLD, 32'hFFFE_0001); end
        default: begin write_reg(swra_pkg::CFG_DECAY, 32'd1280);
                 write_reg(swra_pkg::CFG_THRESHOLD, 32'd0);
                 write_reg(2'd3, 32'hFFFFFFFF); end
      endcase
      stop_cfg();
      // random rows under the new setting
      repeat (RANDOM_ITEMS / 6) begin
        if (row_len == 0) row_len = $urandom_range(1, 8);
        row_len--;
        it = random_entry(row_len == 0);
        send_entry(it);
        // bursts with random gaps
        if ($urandom_range(0, 5) == 0) begin
          stop_push();
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      // close the open row before reconfiguring
      if (row_len != 0) begin
        row_len = 0;
        send_entry(random_entry(1'b1));
      end
      stop_push();
      drain_results();
    end

    stim_done = 1;
    $display("covered %0d items, %0d rows checked (%0d invalid), six register settings",
             items_sent, results_seen, invalid_seen);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[sparse_weighted_row_average] OK");
    else
      $display("[sparse_weighted_row_average] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
